### rtl/efrs_pkg.sv
// efrs_pkg: shared types, constants and the per-channel update function
// for the eFuse fault retry supervisor. No dependencies.
`timescale 1ns / 1ps

package efrs_pkg;

  localparam int unsigned CntW = 8;

  // system mode codes
  localparam logic [1:0] ModeNominal = 2'd0;
  localparam logic [1:0] ModeSafe    = 2'd1;

  // configuration register indexes
  localparam logic [1:0] RegTripThreshold = 2'd0;
  localparam logic [1:0] RegStablePolls   = 2'd1;
  localparam logic [1:0] RegMaxAttempts   = 2'd2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // counters of one channel
  typedef struct packed {
    logic [CntW-1:0] fault_run;
    logic [CntW-1:0] healthy_run;
    logic [CntW-1:0] attempts;
  } chan_cnt_t;

  // thresholds from the configuration registers
  typedef struct packed {
    logic [CntW-1:0] trip_threshold;
    logic [CntW-1:0] stable_polls;
    logic [CntW-1:0] max_attempts;
  } cfg_t;

  // outcome of evaluating one channel
  typedef struct packed {
    chan_cnt_t cnt;
    logic      fault;
    logic      set_ev;
    logic      clr_ev;
    logic      cycle;
  } chan_res_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

  // one tick of a monitored channel against the current fault bit
  function automatic chan_res_t chan_eval(input logic      healthy,
                                          input logic      other_ok,
                                          input logic      fault_in,
                                          input chan_cnt_t cnt,
                                          input cfg_t      cfg);
    chan_res_t r;
    r.cnt    = cnt;
    r.fault  = fault_in;
    r.set_ev = 1'b0;
    r.clr_ev = 1'b0;
    r.cycle  = 1'b0;
    if (healthy) begin
      r.cnt.fault_run   = '0;
      r.cnt.attempts    = '0;
      r.cnt.healthy_run = sat_inc(cnt.healthy_run);
      if ((r.cnt.healthy_run >= cfg.stable_polls) && fault_in && other_ok) begin
        r.fault  = 1'b0;
        r.clr_ev = 1'b1;
      end
    end else begin
      r.cnt.healthy_run = '0;
      r.cnt.fault_run   = sat_inc(cnt.fault_run);
      if (r.cnt.fault_run >= cfg.trip_threshold) begin
        r.fault  = 1'b1;
        r.set_ev = 1'b1;
        if (cnt.attempts < cfg.max_attempts) begin
          r.cnt.attempts  = cnt.attempts + 1'b1;
          r.cnt.fault_run = '0;
          r.cycle         = 1'b1;
        end
      end
    end
    chan_eval = r;
  endfunction

endpackage

### rtl/efuse_fault_retry_supervisor.sv
// efuse_fault_retry_supervisor: top level, input register, channel update
// logic and result register. Depends on efrs_pkg.
`timescale 1ns / 1ps

// Supervisor for two eFuse channels sharing one overcurrent fault bit.
// Input channel (in_valid_i / in_ready_o) carries one poll tick per
// transaction: mode_i and the active-low fault pins pin_a_level_i and
// pin_b_level_i. Output channel (out_valid_o / out_ready_i) returns one
// result per tick: fault_flag_o, cycle_a_o, cycle_b_o, set_event_o and
// clear_event_o. The configuration channel (cfg_valid_i / cfg_ready_o)
// writes trip_threshold (index 0), stable_polls (1) and max_attempts (2);
// other indexes are ignored, and cfg_ready_o is always high.
// A tick lands in the input register at its accepting edge and its result
// is written into the result register once that register is free or being
// read. One tick per cycle is sustained while the receiver does not stall; the
// counter and fault-bit update is a single pass that completes as a tick
// moves from the input register into the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more tick; further ticks wait on in_ready_o.
// Reset clears all counters and the fault bit, empties both registers and
// loads the registers with 3, 5 and 3.
module efuse_fault_retry_supervisor (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // poll ticks
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic       pin_a_level_i,
  input  logic       pin_b_level_i,
  // results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       fault_flag_o,
  output logic       cycle_a_o,
  output logic       cycle_b_o,
  output logic       set_event_o,
  output logic       clear_event_o
);

  efrs_pkg::cfg_t      cfg_q;
  efrs_pkg::chan_cnt_t cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                fault_q, fault_d;

  logic       in_vld_q;
  logic [1:0] mode_q;
  logic       pa_q, pb_q;

  logic out_vld_q;
  logic fault_flag_q, cycle_a_q, cycle_b_q, set_ev_q, clr_ev_q;
  logic cycle_a_d, cycle_b_d, set_ev_d, clr_ev_d;

  logic advance;
  logic mon_a, mon_b;
  efrs_pkg::chan_res_t res_a, res_b;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_threshold <= 8'd3;
      cfg_q.stable_polls   <= 8'd5;
      cfg_q.max_attempts   <= 8'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        efrs_pkg::RegTripThreshold: cfg_q.trip_threshold <= cfg_data_i;
        efrs_pkg::RegStablePolls:   cfg_q.stable_polls   <= cfg_data_i;
        efrs_pkg::RegMaxAttempts:   cfg_q.max_attempts   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_i;
      pa_q   <= pin_a_level_i;
      pb_q   <= pin_b_level_i;
    end
  end

  // channel A first, then channel B against the updated fault bit
  assign mon_a = (mode_q == efrs_pkg::ModeNominal) || (mode_q == efrs_pkg::ModeSafe);
  assign mon_b = (mode_q == efrs_pkg::ModeNominal);

  always_comb begin
    res_a = efrs_pkg::chan_eval(pa_q, !mon_b || pb_q, fault_q, cnt_a_q, cfg_q);
    res_b = efrs_pkg::chan_eval(pb_q, pa_q, mon_a ? res_a.fault : fault_q,
                                cnt_b_q, cfg_q);

    cnt_a_d   = '0;
    cnt_b_d   = '0;
    fault_d   = fault_q;
    cycle_a_d = 1'b0;
    cycle_b_d = 1'b0;
    set_ev_d  = 1'b0;
    clr_ev_d  = 1'b0;

    if (mon_a) begin
      cnt_a_d   = res_a.cnt;
      fault_d   = res_a.fault;
      cycle_a_d = res_a.cycle;
      set_ev_d  = res_a.set_ev;
      clr_ev_d  = res_a.clr_ev;
    end
    if (mon_b) begin
      cnt_b_d   = res_b.cnt;
      fault_d   = res_b.fault;
      cycle_b_d = res_b.cycle;
      set_ev_d  = set_ev_d | res_b.set_ev;
      clr_ev_d  = clr_ev_d | res_b.clr_ev;
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      fault_q <= 1'b0;
    end else if (advance) begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      fault_q <= fault_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fault_flag_q <= fault_d;
      cycle_a_q    <= cycle_a_d;
      cycle_b_q    <= cycle_b_d;
      set_ev_q     <= set_ev_d;
      clr_ev_q     <= clr_ev_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign fault_flag_o  = fault_flag_q;
  assign cycle_a_o     = cycle_a_q;
  assign cycle_b_o     = cycle_b_q;
  assign set_event_o   = set_ev_q;
  assign clear_event_o = clr_ev_q;

endmodule

### tb/sv/efuse_fault_retry_supervisor_test.sv
// efuse_fault_retry_supervisor_test: self-checking testbench for the eFuse
// fault retry supervisor, with its own tick predictor and result checker.
// Depends on efrs_pkg and efuse_fault_retry_supervisor.
`timescale 1ns / 1ps

module efuse_fault_retry_supervisor_test;

  // modes with no monitored channel, and the index with no register behind it
  localparam logic [1:0] ModeOther = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 80;

  // counters of one channel in the predictor
  typedef struct packed {
    logic [efrs_pkg::CntW-1:0] fault_run;
    logic [efrs_pkg::CntW-1:0] healthy_run;
    logic [efrs_pkg::CntW-1:0] attempts;
  } chan_count_t;

  // one result transaction
  typedef struct packed {
    logic fault_flag;
    logic cycle_a;
    logic cycle_b;
    logic set_event;
    logic clear_event;
  } poll_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i   = '0;
  logic [7:0] cfg_data_i    = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [1:0] mode_i        = '0;
  logic       pin_a_level_i = 1'b1;
  logic       pin_b_level_i = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       fault_flag_o;
  logic       cycle_a_o;
  logic       cycle_b_o;
  logic       set_event_o;
  logic       clear_event_o;

  efuse_fault_retry_supervisor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .pin_a_level_i (pin_a_level_i),
    .pin_b_level_i (pin_b_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fault_flag_o  (fault_flag_o),
    .cycle_a_o     (cycle_a_o),
    .cycle_b_o     (cycle_b_o),
    .set_event_o   (set_event_o),
    .clear_event_o (clear_event_o)
  );

  // predictor state and register shadows
  chan_count_t               chan_a, chan_b;
  logic                      fault_shadow;
  logic [efrs_pkg::CntW-1:0] trip_reg, stable_reg, retry_limit;

  poll_result_t expected_results[$];

  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned ticks_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned config_writes   = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_request    = 0;
  int unsigned hold_left       = 0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL efuse_fault_retry_supervisor");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one monitored channel against the shared fault bit
  task automatic step_channel(input logic healthy, input logic other_ok,
                              inout chan_count_t cnt, inout logic set_ev,
                              inout logic clr_ev, output logic cycle_req);
    cycle_req = 1'b0;
    if (healthy) begin
      cnt.fault_run = '0;
      cnt.attempts  = '0;
      if (cnt.healthy_run != efrs_pkg::CntMax) cnt.healthy_run++;
      if (cnt.healthy_run >= stable_reg && fault_shadow && other_ok) begin
        fault_shadow = 1'b0;
        clr_ev       = 1'b1;
      end
    end else begin
      cnt.healthy_run = '0;
      if (cnt.fault_run != efrs_pkg::CntMax) cnt.fault_run++;
      if (cnt.fault_run >= trip_reg) begin
        fault_shadow = 1'b1;
        set_ev       = 1'b1;
        if (cnt.attempts < retry_limit) begin
          cnt.attempts++;
          cnt.fault_run = '0;
          cycle_req     = 1'b1;
        end
      end
    end
  endtask

  // advance the predictor by one poll tick and queue its result
  task automatic predict_poll_tick(input logic [1:0] mode, input logic pin_a,
                                   input logic pin_b);
    poll_result_t res;
    logic         mon_a, mon_b;
    res   = '0;
    mon_a = (mode == efrs_pkg::ModeNominal) || (mode == efrs_pkg::ModeSafe);
    mon_b = (mode == efrs_pkg::ModeNominal);
    // channel A first, so channel B sees its effect on the fault bit
    if (mon_a) begin
      step_channel(pin_a, !mon_b || pin_b, chan_a, res.set_event,
                   res.clear_event, res.cycle_a);
    end else begin
      chan_a = '0;
    end
    if (mon_b) begin
      step_channel(pin_b, pin_a, chan_b, res.set_event, res.clear_event,
                   res.cycle_b);
    end else begin
      chan_b = '0;
    end
    res.fault_flag = fault_shadow;
    expected_results.push_back(res);
  endtask

  // offer one poll tick, with random idle cycles in front
  task automatic send_tick(input logic [1:0] mode, input logic pin_a,
                           input logic pin_b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    pin_a_level_i <= pin_a;
    pin_b_level_i <= pin_b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_poll_tick(mode, pin_a, pin_b);
    ticks_sent++;
  endtask

  // drop valid and wait until every result has come back
  task automatic drain_ticks();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one configuration transaction
  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      efrs_pkg::RegTripThreshold: trip_reg    = data;
      efrs_pkg::RegStablePolls:   stable_reg  = data;
      efrs_pkg::RegMaxAttempts:   retry_limit = data;
      default: begin
      end
    endcase
    config_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [7:0] trip, input logic [7:0] stable,
                                input logic [7:0] attempts);
    drain_ticks();
    write_reg(efrs_pkg::RegTripThreshold, trip);
    write_reg(efrs_pkg::RegStablePolls, stable);
    write_reg(efrs_pkg::RegMaxAttempts, attempts);
  endtask

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return efrs_pkg::ModeNominal;
    if (r < 80) return efrs_pkg::ModeSafe;
    if (r < 90) return ModeOther;
    return ModeSpare;
  endfunction

  // result checker
  task automatic check_bit(input string name, input logic exp, input logic act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0b, actual %0b", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    poll_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no tick outstanding");
        error_count++;
      end else begin
        exp = expected_results.pop_front();
        check_bit("fault_flag", exp.fault_flag, fault_flag_o);
        check_bit("cycle_a", exp.cycle_a, cycle_a_o);
        check_bit("cycle_b", exp.cycle_b, cycle_b_o);
        check_bit("set_event", exp.set_event, set_event_o);
        check_bit("clear_event", exp.clear_event, clear_event_o);
        results_checked++;
      end
    end
  end

  // reset values: trips, retries, both-channel trip, safe-mode clear
  task automatic test_default_thresholds();
    repeat (2) send_tick(efrs_pkg::ModeNominal, 1'b1, 1'b1);
    repeat (3) send_tick(efrs_pkg::ModeNominal, 1'b0, 1'b1);
    repeat (3) send_tick(efrs_pkg::ModeNominal, 1'b0, 1'b0);
    repeat (5) send_tick(efrs_pkg::ModeSafe, 1'b1, 1'b0);
    send_tick(ModeOther, 1'b0, 1'b0);
    send_tick(ModeSpare, 1'b0, 1'b1);
  endtask

  // one-poll thresholds, no retries, then zero thresholds and the spare index
  task automatic test_threshold_extremes();
    set_thresholds(8'd1, 8'd1, 8'd0);
    repeat (2) send_tick(efrs_pkg::ModeNominal, 1'b0, 1'b1);
    send_tick(efrs_pkg::ModeNominal, 1'b1, 1'b0);
    send_tick(efrs_pkg::ModeNominal, 1'b1, 1'b1);
    set_thresholds(8'd0, 8'd0, 8'd255);
    write_reg(RegUnused, 8'hA5);
    send_tick(efrs_pkg::ModeNominal, 1'b1, 1'b1);
    send_tick(efrs_pkg::ModeNominal, 1'b0, 1'b1);
    send_tick(efrs_pkg::ModeSafe, 1'b1, 1'b0);
  endtask

  // runs of steady pin levels with the odd glitch, mixed with noise ticks
  task automatic test_random_polls(input int unsigned send_pct,
                                   input int unsigned recv_pct,
                                   input logic [7:0] trip, input logic [7:0] stable,
                                   input logic [7:0] attempts, input int unsigned n);
    int unsigned count, len, bound;
    logic [1:0]  mode;
    logic        lvl_a, lvl_b;
    set_thresholds(trip, stable, attempts);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 15) begin
        send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        count++;
      end else begin
        bound = ((trip > stable) ? trip : stable) + 3;
        if (bound > 40) bound = 40;
        len   = $urandom_range(1, bound);
        mode  = pick_mode();
        lvl_a = 1'($urandom_range(1));
        lvl_b = 1'($urandom_range(1));
        repeat (len) begin
          if ($urandom_range(99) < 5) send_tick(mode, !lvl_a, lvl_b);
          else send_tick(mode, lvl_a, lvl_b);
        end
        count += len;
      end
    end
  endtask

  // long receiver hold-off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    drain_ticks();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HoldCycles;
    repeat (24) send_tick(pick_mode(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // fault run on channel A and healthy run on channel B past 255 polls at the
  // largest thresholds, then the clear once both pins are healthy
  task automatic test_counter_saturation();
    set_thresholds(8'd255, 8'd255, 8'd0);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    repeat (258) send_tick(efrs_pkg::ModeNominal, 1'b0, 1'b1);
    send_tick(efrs_pkg::ModeNominal, 1'b1, 1'b1);
    set_thresholds(8'd3, 8'd5, 8'd3);
  endtask

  initial begin
    chan_a       = '0;
    chan_b       = '0;
    fault_shadow = 1'b0;
    trip_reg     = 8'd3;
    stable_reg   = 8'd5;
    retry_limit  = 8'd3;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_thresholds();
    test_threshold_extremes();
    test_random_polls(0, 0, 8'd3, 8'd5, 8'd3, 75);
    test_random_polls(46, 0, 8'd1, 8'd1, 8'd0, 75);
    test_random_polls(0, 46, 8'd2, 8'd7, 8'd255, 75);
    test_random_polls(15, 15, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 10)),
                      8'($urandom_range(0, 4)), 75);
    test_backpressure();
    test_counter_saturation();
    drain_ticks();

    $display("covered %0d poll ticks, %0d results checked, %0d register writes",
             ticks_sent, results_checked, config_writes);
    $display("with threshold extremes, counter saturation, stalls and a long hold-off");
    if (error_count == 0) begin
      $display("PASS efuse_fault_retry_supervisor");
    end else begin
      $display("FAIL efuse_fault_retry_supervisor");
    end
    $finish;
  end

endmodule

### sim.f
rtl/efrs_pkg.sv
rtl/efuse_fault_retry_supervisor.sv
tb/sv/efuse_fault_retry_supervisor_test.sv
